// File: hdl/assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SPQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/spq_pkg.sv
// Package: types and constants of the sorted priority queue.
package spq_pkg;

    // Number of cells in the queue
    localparam int DEPTH = 16;
    // Count register wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int VALUE_W    = 32;
    localparam int PRIORITY_W = 16;
    localparam int OUT_CNT_W  = 5;

    // Operation codes carried in tuser
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0]    value;
        logic signed [PRIORITY_W-1:0] prio;
    } t_entry;

    // Command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cmd;

endpackage

// File: hdl/spq_cell.sv
// One cell of the systolic queue: holds an entry and trades it with its neighbors.
module spq_cell
    import spq_pkg::*;
(
    input  logic   i_clk,
    input  t_cmd   i_cmd,        // broadcast insert/remove command
    input  logic   i_occupied,   // this cell holds a live entry
    input  t_entry i_left,       // entry of the cell nearer the head
    input  logic   i_left_keep,  // left cell keeps its entry on insert
    input  t_entry i_right,      // entry of the cell nearer the tail
    output t_entry o_entry,
    output logic   o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // Live entry stays ahead of the new one when its priority is not lower
    assign o_keep  = i_occupied && (r_entry.prio >= i_cmd.item.prio);
    assign o_entry = r_entry;

    // Insert: hold, take the new item, or shift toward the tail; remove: shift toward head
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_cmd.item;
            end else begin
                n_entry = i_left;
            end
        end else if (i_cmd.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hdl/sorted_priority_queue.sv
// Top level: sorted priority queue built from a row of shifting cells.
//
//  channel | dir | tdata (low bit up)                             | tuser (low bit up)
//  --------+-----+------------------------------------------------+-----------------------
//  s_      | in  | item_value[31:0], item_priority[47:32]         | kind[0]
//  m_      | out | out_value[31:0], out_priority[47:32],          | out_valid[0],
//          |     | entry_count[52:48], zero fill[55:53]           | status[2:1]
//
// One word per cycle while the input is not stalled: every cell compares its
// priority with the incoming one in parallel and shifts by one place, and the
// result appears in the output register the next cycle.
// Reset (i_rst_n low, synchronous) clears the entry count and m_tvalid.
// The input is stalled only while a result waits in the output register and
// m_tready is low.
`include "assert_macros.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_value[31:0], item_priority[47:32]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_value[31:0], out_priority[47:32], entry_count[52:48]
    output logic [2:0]  m_tuser    // out_valid[0], status[2:1]
);

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_kind            w_kind;
    t_cmd             w_cmd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W+OUT_CNT_W-1:0] w_count_ext;

    t_entry w_entry [DEPTH];
    logic   w_keep  [DEPTH];
    logic   w_occ   [DEPTH];

    logic                  r_m_tvalid;
    logic [VALUE_W-1:0]    r_out_value;
    logic [PRIORITY_W-1:0] r_out_prio;
    logic                  r_out_valid;
    t_status               r_status;
    logic [OUT_CNT_W-1:0]  r_entry_count;

    logic                  n_out_valid;
    t_status               n_status;

    // Handshake and decode
    assign s_tready = !r_m_tvalid || m_tready;
    assign w_accept = s_tvalid && s_tready;
    assign w_kind   = t_kind'(s_tuser[0]);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_cmd.ins        = w_accept && (w_kind == KIND_INSERT) && !w_full;
    assign w_cmd.rem        = w_accept && (w_kind == KIND_REMOVE) && !w_empty;
    assign w_cmd.item.value = s_tdata[31:0];
    assign w_cmd.item.prio  = s_tdata[47:32];

    // Row of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_keep;
        t_entry w_right;

        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left      = w_cmd.item;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_entry[g-1];
            assign w_left_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (w_occ[g]),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_keep      (w_keep[g])
        );
    end

    // Entry count update
    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result status
    always_comb begin
        n_status    = ST_OK;
        n_out_valid = 1'b0;
        unique case (w_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end
            end
            KIND_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_count_ext = {{OUT_CNT_W{1'b0}}, n_count};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_accept) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value   <= n_out_valid ? w_entry[0].value : '0;
            r_out_prio    <= n_out_valid ? w_entry[0].prio  : '0;
            r_out_valid   <= n_out_valid;
            r_status      <= n_status;
            r_entry_count <= w_count_ext[OUT_CNT_W-1:0];
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {3'b000, r_entry_count, r_out_prio, r_out_value};
    assign m_tuser  = {r_status, r_out_valid};

    // Checks
    `SPQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count above depth")
    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_rst_n && w_cmd.ins, r_count == $past(r_count) + CNT_W'(1), "insert did not grow count")
    `SPQ_ASSERT_NEXT(a_empty_flag, i_clk, i_rst_n, i_rst_n && w_accept && (w_kind == KIND_REMOVE) && w_empty, (r_status == ST_EMPTY) && !r_out_valid, "remove on empty not flagged")
    `SPQ_ASSERT_NOW(a_valid_ok, i_clk, i_rst_n, m_tvalid && r_out_valid, r_status == ST_OK, "returned entry with error status")

endmodule

// File: sim/sorted_priority_queue_tb.sv
// Testbench for the sorted priority queue: directed and random traffic checked against a predictor.
module sorted_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // One result word, unpacked into its fields
    typedef struct packed {
        logic [31:0] value;
        logic [15:0] prio;
        logic        valid;
        t_status     status;
        logic [4:0]  count;
    } t_reply;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // item_value[31:0], item_priority[47:32]
    logic [0:0]  s_tuser  = '0;   // kind[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // out_value[31:0], out_priority[47:32], entry_count[52:48]
    logic [2:0]  m_tuser;         // out_valid[0], status[2:1]

    // Predictor state: entries head first, and how many are held
    t_entry held[DEPTH];
    int     held_n = 0;

    t_reply      pending_replies[$];
    int unsigned mismatches = 0;
    bit          gaps_on    = 1'b1;

    sorted_priority_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the predicted queue and return the result it yields
    function automatic t_reply predict_queue_op(t_kind k, logic [31:0] v,
                                                logic signed [15:0] p);
        t_reply r;
        int     pos;
        r = '0;
        r.status = ST_OK;
        if (k == KIND_INSERT) begin
            if (held_n >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind every entry of greater or equal priority
                pos = 0;
                while (pos < held_n && held[pos].prio >= p) pos++;
                for (int i = held_n; i > pos; i--) held[i] = held[i-1];
                held[pos].value = v;
                held[pos].prio  = p;
                held_n++;
            end
        end else if (held_n == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.value = held[0].value;
            r.prio  = held[0].prio;
            r.valid = 1'b1;
            for (int i = 1; i < held_n; i++) held[i-1] = held[i];
            held_n--;
        end
        r.count = 5'(held_n);
        return r;
    endfunction

    // Send one word; returns right after the edge that accepted it
    task automatic send_word(t_kind k, logic [31:0] v, logic [15:0] p);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p, v};
        s_tuser  <= k;
        do @(posedge i_clk); while (!s_tready);
        pending_replies.push_back(predict_queue_op(k, v, p));
    endtask

    // Random priority: full range, a narrow band for ties, or an extreme
    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 6)) - 16'd3;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_op(int unsigned insert_pct);
        t_kind       k;
        logic [31:0] v;
        k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            default: v = $urandom;
        endcase
        send_word(k, v, pick_priority());
    endtask

    task automatic test_remove_empty();
        send_word(KIND_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Extreme values and priorities, ties served in arrival order
    task automatic test_priority_order();
        send_word(KIND_INSERT, 32'h7FFF_FFFF, 16'h0000);
        send_word(KIND_INSERT, 32'h8000_0000, 16'h8000);
        send_word(KIND_INSERT, 32'h0000_0000, 16'h7FFF);
        send_word(KIND_INSERT, 32'h0000_0001, 16'h0000);
        send_word(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000);
        send_word(KIND_INSERT, 32'h0000_0005, 16'h7FFF);
        repeat (3) send_word(KIND_REMOVE, $urandom, 16'($urandom));
    endtask

    // Top up to full, then an insert that must be rejected
    task automatic test_fill_to_overflow();
        for (int i = 0; i < DEPTH - 3; i++) begin
            send_word(KIND_INSERT, $urandom,
                      (i % 3 == 0) ? 16'h0000 : 16'($urandom_range(0, 4)) - 16'd2);
        end
        send_word(KIND_INSERT, 32'hA5A5_5A5A, 16'h7FFF);
    endtask

    // Blocks of random traffic, each leaning toward filling, draining or neither
    task automatic test_random_traffic();
        int unsigned insert_pct;
        for (int blk = 0; blk < 33; blk++) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (40) send_random_op(insert_pct);
        end
    endtask

    // Back-to-back words with the sink always ready
    task automatic test_streaming_no_gaps();
        gaps_on = 1'b0;
        repeat (100) send_random_op(70);
        repeat (100) send_random_op(30);
    endtask

    // Sink readiness: random stall bursts while gaps are enabled
    initial begin
        @(posedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.value  = m_tdata[31:0];
            got.prio   = m_tdata[47:32];
            got.count  = m_tdata[52:48];
            got.valid  = m_tuser[0];
            got.status = t_status'(m_tuser[2:1]);
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result word: %p", $realtime, got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] mismatch: expected %p, got %p", $realtime, want, got);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_remove_empty();
        test_priority_order();
        test_fill_to_overflow();
        test_random_traffic();
        test_streaming_no_gaps();
        s_tvalid <= 1'b0;
        for (int n = 0; n < 1000 && pending_replies.size() != 0; n++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
